[hdl/svd_pkg.sv]
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types, register indexes and constant tables of the space-vector
// duty calculator.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int ANGLE_W     = 9;
    localparam int DUTY_W      = 16;
    localparam int SECTOR_W    = 3;
    localparam int REM_W       = 6;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int TAB_W       = 16;
    localparam int SCALE_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULATION_INDEX = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD       = 4'd1;

    localparam logic [CFG_DATA_W-1:0] MODULATION_RESET = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] PERIOD_RESET     = 16'd719;

    localparam logic [ANGLE_W-1:0] FULL_TURN  = 9'd360;
    localparam logic [REM_W-1:0]   SECTOR_DEG = 6'd60;

    typedef logic [1:0] phase_sel_t;
    localparam phase_sel_t SEL_ZERO = 2'd0;
    localparam phase_sel_t SEL_T1   = 2'd1;
    localparam phase_sel_t SEL_T2   = 2'd2;
    localparam phase_sel_t SEL_SUM  = 2'd3;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [REM_W-1:0]    rem;
        logic [SCALE_W-1:0]  scale;
    } sec_stage_t;

    // 0.8660254 * sin(k deg) in Q0.16, k = 0..60
    function automatic logic [TAB_W-1:0] sin_lut(input logic [REM_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            6'd0:  v = 16'd0;
            6'd1:  v = 16'd991;
            6'd2:  v = 16'd1981;
            6'd3:  v = 16'd2970;
            6'd4:  v = 16'd3959;
            6'd5:  v = 16'd4947;
            6'd6:  v = 16'd5933;
            6'd7:  v = 16'd6917;
            6'd8:  v = 16'd7899;
            6'd9:  v = 16'd8879;
            6'd10: v = 16'd9856;
            6'd11: v = 16'd10830;
            6'd12: v = 16'd11800;
            6'd13: v = 16'd12767;
            6'd14: v = 16'd13730;
            6'd15: v = 16'd14689;
            6'd16: v = 16'd15644;
            6'd17: v = 16'd16594;
            6'd18: v = 16'd17539;
            6'd19: v = 16'd18478;
            6'd20: v = 16'd19412;
            6'd21: v = 16'd20339;
            6'd22: v = 16'd21261;
            6'd23: v = 16'd22176;
            6'd24: v = 16'd23085;
            6'd25: v = 16'd23986;
            6'd26: v = 16'd24880;
            6'd27: v = 16'd25767;
            6'd28: v = 16'd26645;
            6'd29: v = 16'd27516;
            6'd30: v = 16'd28378;
            6'd31: v = 16'd29231;
            6'd32: v = 16'd30076;
            6'd33: v = 16'd30911;
            6'd34: v = 16'd31737;
            6'd35: v = 16'd32554;
            6'd36: v = 16'd33360;
            6'd37: v = 16'd34157;
            6'd38: v = 16'd34942;
            6'd39: v = 16'd35718;
            6'd40: v = 16'd36482;
            6'd41: v = 16'd37235;
            6'd42: v = 16'd37977;
            6'd43: v = 16'd38707;
            6'd44: v = 16'd39426;
            6'd45: v = 16'd40132;
            6'd46: v = 16'd40827;
            6'd47: v = 16'd41509;
            6'd48: v = 16'd42178;
            6'd49: v = 16'd42834;
            6'd50: v = 16'd43477;
            6'd51: v = 16'd44108;
            6'd52: v = 16'd44724;
            6'd53: v = 16'd45327;
            6'd54: v = 16'd45916;
            6'd55: v = 16'd46492;
            6'd56: v = 16'd47053;
            6'd57: v = 16'd47599;
            6'd58: v = 16'd48132;
            6'd59: v = 16'd48649;
            6'd60: v = 16'd49152;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Phase term per sector: U, V, W
    function automatic phase_sel_t phase_sel(input logic [SECTOR_W-1:0] sector,
                                             input logic [1:0] phase);
        phase_sel_t u;
        phase_sel_t v;
        phase_sel_t w;
        phase_sel_t s;
        case (sector)
            3'd0:    begin u = SEL_SUM;  v = SEL_T2;   w = SEL_ZERO; end
            3'd1:    begin u = SEL_T1;   v = SEL_SUM;  w = SEL_ZERO; end
            3'd2:    begin u = SEL_ZERO; v = SEL_SUM;  w = SEL_T2;   end
            3'd3:    begin u = SEL_ZERO; v = SEL_T1;   w = SEL_SUM;  end
            3'd4:    begin u = SEL_T2;   v = SEL_ZERO; w = SEL_SUM;  end
            3'd5:    begin u = SEL_SUM;  v = SEL_ZERO; w = SEL_T1;   end
            default: begin u = SEL_ZERO; v = SEL_ZERO; w = SEL_ZERO; end
        endcase
        case (phase)
            2'd0:    s = u;
            2'd1:    s = v;
            2'd2:    s = w;
            default: s = SEL_ZERO;
        endcase
        return s;
    endfunction

endpackage

[hdl/svd_if.sv]
// ----------------------------------------------------------------------------
// svd_if
// Valid/ready channels of the space-vector duty calculator: angle input,
// duty result and configuration write.
// ----------------------------------------------------------------------------
interface svd_in_if;
    logic                         valid;
    logic                         ready;
    logic [svd_pkg::ANGLE_W-1:0]  angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

interface svd_out_if;
    logic                          valid;
    logic                          ready;
    logic [svd_pkg::DUTY_W-1:0]    duty_u;
    logic [svd_pkg::DUTY_W-1:0]    duty_v;
    logic [svd_pkg::DUTY_W-1:0]    duty_w;
    logic [svd_pkg::SECTOR_W-1:0]  sector;

    modport source (output valid, output duty_u, output duty_v, output duty_w,
                    output sector, input ready);
    modport sink   (input valid, input duty_u, input duty_v, input duty_w,
                    input sector, output ready);
endinterface

interface svd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [svd_pkg::CFG_INDEX_W-1:0] index;
    logic [svd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/svd_sector.sv]
// ----------------------------------------------------------------------------
// svd_sector
// Stage 1: wrap the angle, split it into sector and in-sector angle, and
// form the combined modulation and period scale.
// ----------------------------------------------------------------------------
module svd_sector
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [svd_pkg::ANGLE_W-1:0]     angle_deg,
    input  logic [svd_pkg::CFG_DATA_W-1:0]  modulation_index,
    input  logic [svd_pkg::CFG_DATA_W-1:0]  pwm_period,
    output logic                            out_valid,
    input  logic                            out_ready,
    output svd_pkg::sec_stage_t             out_data
);

    logic                             valid_reg;
    svd_pkg::sec_stage_t              data_reg;
    svd_pkg::sec_stage_t              data_next;
    logic [svd_pkg::ANGLE_W-1:0]      wrapped;
    logic [svd_pkg::ANGLE_W-1:0]      base;
    logic [svd_pkg::ANGLE_W-1:0]      diff;

    always_comb
    begin
        wrapped = (angle_deg >= svd_pkg::FULL_TURN) ? angle_deg - svd_pkg::FULL_TURN
                                                    : angle_deg;
        if (wrapped >= 9'd300)
        begin
            data_next.sector = 3'd5;
            base             = 9'd300;
        end
        else if (wrapped >= 9'd240)
        begin
            data_next.sector = 3'd4;
            base             = 9'd240;
        end
        else if (wrapped >= 9'd180)
        begin
            data_next.sector = 3'd3;
            base             = 9'd180;
        end
        else if (wrapped >= 9'd120)
        begin
            data_next.sector = 3'd2;
            base             = 9'd120;
        end
        else if (wrapped >= 9'd60)
        begin
            data_next.sector = 3'd1;
            base             = 9'd60;
        end
        else
        begin
            data_next.sector = 3'd0;
            base             = 9'd0;
        end
        diff            = wrapped - base;
        data_next.rem   = diff[svd_pkg::REM_W-1:0];
        data_next.scale = svd_pkg::SCALE_W'(modulation_index) *
                          svd_pkg::SCALE_W'(pwm_period);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

[hdl/svd_coef.sv]
// ----------------------------------------------------------------------------
// svd_coef
// Stage 2: look up the two dwell terms, bring them to the coefficient width
// and pick the term of each phase.
// ----------------------------------------------------------------------------
module svd_coef
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  svd_pkg::sec_stage_t                in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [svd_pkg::SECTOR_W-1:0]       out_sector,
    output logic [svd_pkg::SCALE_W-1:0]        out_scale,
    output logic [2:0][COEF_WIDTH:0]           out_coef
);

    localparam int SH_UP = (COEF_WIDTH >= svd_pkg::TAB_W) ? COEF_WIDTH - svd_pkg::TAB_W : 0;
    localparam int SH_DN = (COEF_WIDTH < svd_pkg::TAB_W) ? svd_pkg::TAB_W - COEF_WIDTH : 0;
    localparam logic [svd_pkg::TAB_W:0] HALF = (svd_pkg::TAB_W+1)'((1 << SH_DN) >> 1);

    logic                          valid_reg;
    logic [svd_pkg::SECTOR_W-1:0]  sector_reg;
    logic [svd_pkg::SCALE_W-1:0]   scale_reg;
    logic [2:0][COEF_WIDTH:0]      coef_reg;
    logic [2:0][COEF_WIDTH:0]      coef_next;
    logic [svd_pkg::TAB_W-1:0]     tab1;
    logic [svd_pkg::TAB_W-1:0]     tab2;
    logic [COEF_WIDTH-1:0]         c1;
    logic [COEF_WIDTH-1:0]         c2;
    logic [COEF_WIDTH:0]           csum;
    logic [svd_pkg::TAB_W:0]       r1;
    logic [svd_pkg::TAB_W:0]       r2;

    always_comb
    begin
        tab1 = svd_pkg::sin_lut(svd_pkg::SECTOR_DEG - in_data.rem);
        tab2 = svd_pkg::sin_lut(in_data.rem);
        r1   = ({1'b0, tab1} + HALF) >> SH_DN;
        r2   = ({1'b0, tab2} + HALF) >> SH_DN;
        if (COEF_WIDTH >= svd_pkg::TAB_W)
        begin
            c1 = COEF_WIDTH'(tab1) << SH_UP;
            c2 = COEF_WIDTH'(tab2) << SH_UP;
        end
        else
        begin
            c1 = COEF_WIDTH'(r1);
            c2 = COEF_WIDTH'(r2);
        end
        csum = {1'b0, c1} + {1'b0, c2};
        for (int p = 0; p < 3; p++)
        begin
            case (svd_pkg::phase_sel(in_data.sector, 2'(p)))
                svd_pkg::SEL_T1:  coef_next[p] = {1'b0, c1};
                svd_pkg::SEL_T2:  coef_next[p] = {1'b0, c2};
                svd_pkg::SEL_SUM: coef_next[p] = csum;
                default:          coef_next[p] = '0;
            endcase
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_sector = sector_reg;
    assign out_scale  = scale_reg;
    assign out_coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sector_reg <= in_data.sector;
            scale_reg  <= in_data.scale;
            coef_reg   <= coef_next;
        end
    end

endmodule

[hdl/svd_mult.sv]
// ----------------------------------------------------------------------------
// svd_mult
// Stage 3: multiply each phase coefficient by the modulation and period scale.
// ----------------------------------------------------------------------------
module svd_mult
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [svd_pkg::SECTOR_W-1:0]                  in_sector,
    input  logic [svd_pkg::SCALE_W-1:0]                   in_scale,
    input  logic [2:0][COEF_WIDTH:0]                      in_coef,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [svd_pkg::SECTOR_W-1:0]                  out_sector,
    output logic [2:0][COEF_WIDTH+svd_pkg::SCALE_W:0]     out_prod
);

    localparam int PROD_W = COEF_WIDTH + svd_pkg::SCALE_W + 1;

    logic                          valid_reg;
    logic [svd_pkg::SECTOR_W-1:0]  sector_reg;
    logic [2:0][PROD_W-1:0]        prod_reg;
    logic [2:0][PROD_W-1:0]        prod_next;

    always_comb
    begin
        for (int p = 0; p < 3; p++)
            prod_next[p] = PROD_W'(in_coef[p]) * PROD_W'(in_scale);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_sector = sector_reg;
    assign out_prod   = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sector_reg <= in_sector;
            prod_reg   <= prod_next;
        end
    end

endmodule

[hdl/svd_sat.sv]
// ----------------------------------------------------------------------------
// svd_sat
// Stage 4: drop the fraction bits, saturate to 16 bits and hold the result
// for the output transaction.
// ----------------------------------------------------------------------------
module svd_sat
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [svd_pkg::SECTOR_W-1:0]                  in_sector,
    input  logic [2:0][COEF_WIDTH+svd_pkg::SCALE_W:0]     in_prod,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [svd_pkg::SECTOR_W-1:0]                  out_sector,
    output logic [2:0][svd_pkg::DUTY_W-1:0]               out_duty
);

    localparam int PROD_W = COEF_WIDTH + svd_pkg::SCALE_W + 1;
    localparam int FRAC_W = COEF_WIDTH + 15;
    localparam int HI_W   = PROD_W - FRAC_W;

    logic                              valid_reg;
    logic [svd_pkg::SECTOR_W-1:0]      sector_reg;
    logic [2:0][svd_pkg::DUTY_W-1:0]   duty_reg;
    logic [2:0][svd_pkg::DUTY_W-1:0]   duty_next;
    logic [2:0][HI_W-1:0]              whole;

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            whole[p] = in_prod[p][PROD_W-1:FRAC_W];
            if (whole[p][HI_W-1:svd_pkg::DUTY_W] != '0)
                duty_next[p] = '1;
            else
                duty_next[p] = whole[p][svd_pkg::DUTY_W-1:0];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_sector = sector_reg;
    assign out_duty   = duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sector_reg <= in_sector;
            duty_reg   <= duty_next;
        end
    end

endmodule

[hdl/space_vector_duty_calculator_core.sv]
// An angle is registered in the sector, coefficient, multiply and saturate
// stages in turn. Throughput: one angle per cycle while duty.ready is high,
// set by the four-stage pipeline with one multiplier per phase in stage 3.
// Reset: clears all stage valid bits; modulation index returns to 32768 and
// PWM period to 719. The configuration port accepts a write every cycle.
// ----------------------------------------------------------------------------
// space_vector_duty_calculator_core
// Space-vector PWM duty calculator: angle in, three phase compare values and
// the sector out, pipelined in four stages.
// ----------------------------------------------------------------------------
module space_vector_duty_calculator_core
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    svd_in_if.sink           angle,
    svd_out_if.source        duty,
    svd_cfg_if.sink          cfg
);

    logic [svd_pkg::CFG_DATA_W-1:0]                modulation_index_reg;
    logic [svd_pkg::CFG_DATA_W-1:0]                pwm_period_reg;

    logic                                          s1_valid;
    logic                                          s1_ready;
    svd_pkg::sec_stage_t                           s1_data;
    logic                                          s2_valid;
    logic                                          s2_ready;
    logic [svd_pkg::SECTOR_W-1:0]                  s2_sector;
    logic [svd_pkg::SCALE_W-1:0]                   s2_scale;
    logic [2:0][COEF_WIDTH:0]                      s2_coef;
    logic                                          s3_valid;
    logic                                          s3_ready;
    logic [svd_pkg::SECTOR_W-1:0]                  s3_sector;
    logic [2:0][COEF_WIDTH+svd_pkg::SCALE_W:0]     s3_prod;
    logic                                          s4_valid;
    logic [svd_pkg::SECTOR_W-1:0]                  s4_sector;
    logic [2:0][svd_pkg::DUTY_W-1:0]               s4_duty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_index_reg <= svd_pkg::MODULATION_RESET;
            pwm_period_reg       <= svd_pkg::PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                svd_pkg::CFG_MODULATION_INDEX: modulation_index_reg <= cfg.data;
                svd_pkg::CFG_PWM_PERIOD:       pwm_period_reg       <= cfg.data;
                default:                       ;
            endcase
        end
    end

    svd_sector u_sector
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (angle.valid),
        .in_ready         (angle.ready),
        .angle_deg        (angle.angle_deg),
        .modulation_index (modulation_index_reg),
        .pwm_period       (pwm_period_reg),
        .out_valid        (s1_valid),
        .out_ready        (s1_ready),
        .out_data         (s1_data)
    );

    svd_coef #(.COEF_WIDTH(COEF_WIDTH)) u_coef
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_ready   (s1_ready),
        .in_data    (s1_data),
        .out_valid  (s2_valid),
        .out_ready  (s2_ready),
        .out_sector (s2_sector),
        .out_scale  (s2_scale),
        .out_coef   (s2_coef)
    );

    svd_mult #(.COEF_WIDTH(COEF_WIDTH)) u_mult
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_sector  (s2_sector),
        .in_scale   (s2_scale),
        .in_coef    (s2_coef),
        .out_valid  (s3_valid),
        .out_ready  (s3_ready),
        .out_sector (s3_sector),
        .out_prod   (s3_prod)
    );

    svd_sat #(.COEF_WIDTH(COEF_WIDTH)) u_sat
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_sector  (s3_sector),
        .in_prod    (s3_prod),
        .out_valid  (s4_valid),
        .out_ready  (duty.ready),
        .out_sector (s4_sector),
        .out_duty   (s4_duty)
    );

    assign duty.valid  = s4_valid;
    assign duty.sector = s4_sector;
    assign duty.duty_u = s4_duty[0];
    assign duty.duty_v = s4_duty[1];
    assign duty.duty_w = s4_duty[2];

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid |-> (s4_sector <= 3'd5))
        else $error("sector out of range");

    a_w_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid && (s4_sector == 3'd0 || s4_sector == 3'd1) |-> (s4_duty[2] == '0))
        else $error("phase W active in sector 0 or 1");

    a_u_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid && (s4_sector == 3'd2 || s4_sector == 3'd3) |-> (s4_duty[0] == '0))
        else $error("phase U active in sector 2 or 3");

    a_v_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid && (s4_sector == 3'd4 || s4_sector == 3'd5) |-> (s4_duty[1] == '0))
        else $error("phase V active in sector 4 or 5");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives electrical angles into the space-vector duty calculator under a
// series of modulation depths and PWM periods, and checks every phase duty
// and sector against an in-bench duty predictor, with random gaps on the
// angle channel and random back-pressure on the duty channel.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COEF_W     = 16;
    localparam int LATENCY    = 4;
    localparam int IDLE_PCT   = 34;
    localparam logic [svd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 4'd2;
    localparam logic [svd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 4'd15;

    typedef struct packed {
        logic [svd_pkg::DUTY_W-1:0]   duty_u;
        logic [svd_pkg::DUTY_W-1:0]   duty_v;
        logic [svd_pkg::DUTY_W-1:0]   duty_w;
        logic [svd_pkg::SECTOR_W-1:0] sector;
    } duty_set_t;

    logic clk = 1'b0;
    logic rst_n;

    svd_in_if  angle_if ();
    svd_out_if duty_if ();
    svd_cfg_if cfg_if ();

    space_vector_duty_calculator_core #(.COEF_WIDTH(COEF_W)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .angle (angle_if),
        .duty  (duty_if),
        .cfg   (cfg_if)
    );

    // 0.8660254 * sin(k deg) in Q0.16, k = 0..60
    logic [15:0] sin_q16 [0:60] = '{
            0,   991,  1981,  2970,  3959,  4947,  5933,  6917,  7899,  8879,
         9856, 10830, 11800, 12767, 13730, 14689, 15644, 16594, 17539, 18478,
        19412, 20339, 21261, 22176, 23085, 23986, 24880, 25767, 26645, 27516,
        28378, 29231, 30076, 30911, 31737, 32554, 33360, 34157, 34942, 35718,
        36482, 37235, 37977, 38707, 39426, 40132, 40827, 41509, 42178, 42834,
        43477, 44108, 44724, 45327, 45916, 46492, 47053, 47599, 48132, 48649,
        49152
    };

    svd_pkg::phase_sel_t sector_terms [0:5][0:2] = '{
        '{svd_pkg::SEL_SUM,  svd_pkg::SEL_T2,   svd_pkg::SEL_ZERO},
        '{svd_pkg::SEL_T1,   svd_pkg::SEL_SUM,  svd_pkg::SEL_ZERO},
        '{svd_pkg::SEL_ZERO, svd_pkg::SEL_SUM,  svd_pkg::SEL_T2  },
        '{svd_pkg::SEL_ZERO, svd_pkg::SEL_T1,   svd_pkg::SEL_SUM },
        '{svd_pkg::SEL_T2,   svd_pkg::SEL_ZERO, svd_pkg::SEL_SUM },
        '{svd_pkg::SEL_SUM,  svd_pkg::SEL_ZERO, svd_pkg::SEL_T1  }
    };

    logic [svd_pkg::ANGLE_W-1:0] boundary_angles [0:19] = '{
        0, 1, 29, 30, 31, 59, 60, 61, 119, 120,
        180, 240, 255, 256, 300, 359, 360, 361, 420, 511
    };

    logic [svd_pkg::ANGLE_W-1:0] pending_angles [$];
    duty_set_t                   expected_duties [$];
    duty_set_t                   want;

    logic [svd_pkg::CFG_DATA_W-1:0] mod_index;
    logic [svd_pkg::CFG_DATA_W-1:0] period;

    int idle_pct;
    int angles_queued;
    int angles_sent;
    int results_checked;
    int settings_used;
    int mismatches;

    always #2 clk = ~clk;

    function automatic logic [63:0] coef_of(input logic [15:0] raw);
        if (COEF_W >= 16)
            return 64'(raw) << (COEF_W - 16);
        return (64'(raw) + ((64'd1 << (16 - COEF_W)) >> 1)) >> (16 - COEF_W);
    endfunction

    function automatic duty_set_t svm_duties(input logic [svd_pkg::ANGLE_W-1:0] angle_in,
                                             input logic [svd_pkg::CFG_DATA_W-1:0] depth,
                                             input logic [svd_pkg::CFG_DATA_W-1:0] counts);
        logic [svd_pkg::ANGLE_W-1:0] a;
        int unsigned                 sec;
        int unsigned                 r;
        logic [63:0]                 term [0:3];
        logic [63:0]                 scaled [0:2];
        duty_set_t                   res;

        a = angle_in;
        if (a >= svd_pkg::FULL_TURN)
            a = a - svd_pkg::FULL_TURN;
        sec = a / 60;
        r = a % 60;
        term[svd_pkg::SEL_ZERO] = '0;
        term[svd_pkg::SEL_T1]   = coef_of(sin_q16[60 - r]);
        term[svd_pkg::SEL_T2]   = coef_of(sin_q16[r]);
        term[svd_pkg::SEL_SUM]  = term[svd_pkg::SEL_T1] + term[svd_pkg::SEL_T2];
        for (int p = 0; p < 3; p++)
        begin
            scaled[p] = (term[sector_terms[sec][p]] * 64'(depth) * 64'(counts))
                        >> (COEF_W + 15);
            if (scaled[p] > 64'hFFFF)
                scaled[p] = 64'hFFFF;
        end
        res.duty_u = scaled[0][svd_pkg::DUTY_W-1:0];
        res.duty_v = scaled[1][svd_pkg::DUTY_W-1:0];
        res.duty_w = scaled[2][svd_pkg::DUTY_W-1:0];
        res.sector = sec[svd_pkg::SECTOR_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string field, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // angle driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_if.valid     <= 1'b0;
            angle_if.angle_deg <= '0;
        end
        else
        begin
            if (angle_if.valid && angle_if.ready)
            begin
                expected_duties.push_back(svm_duties(angle_if.angle_deg, mod_index, period));
                angles_sent++;
            end
            if (!angle_if.valid || angle_if.ready)
            begin
                if (pending_angles.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    angle_if.valid     <= 1'b1;
                    angle_if.angle_deg <= pending_angles.pop_front();
                end
                else
                    angle_if.valid <= 1'b0;
            end
        end
    end

    // duty monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_if.ready <= 1'b0;
        else
        begin
            if (duty_if.valid && duty_if.ready)
            begin
                if (expected_duties.size() == 0)
                begin
                    $display("%0t: extra result, expected none, actual %0d %0d %0d %0d",
                             $time, duty_if.duty_u, duty_if.duty_v, duty_if.duty_w,
                             duty_if.sector);
                    mismatches++;
                end
                else
                begin
                    want = expected_duties.pop_front();
                    check_field("duty_u", want.duty_u, duty_if.duty_u);
                    check_field("duty_v", want.duty_v, duty_if.duty_v);
                    check_field("duty_w", want.duty_w, duty_if.duty_w);
                    check_field("sector", want.sector, duty_if.sector);
                end
                results_checked++;
            end
            duty_if.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic write_reg(input logic [svd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [svd_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            svd_pkg::CFG_MODULATION_INDEX: mod_index = value;
            svd_pkg::CFG_PWM_PERIOD:       period = value;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_drive(input logic [svd_pkg::CFG_DATA_W-1:0] depth,
                             input logic [svd_pkg::CFG_DATA_W-1:0] counts);
        write_reg(svd_pkg::CFG_MODULATION_INDEX, depth);
        write_reg(svd_pkg::CFG_PWM_PERIOD, counts);
        settings_used++;
    endtask

    // hold until every queued angle has been sent and its result checked
    task automatic drain;
        do
            @(posedge clk);
        while (angles_sent != angles_queued || expected_duties.size() != 0);
    endtask

    task automatic run_angles(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_angles.push_back(svd_pkg::ANGLE_W'($urandom_range(360, 511)));
            else
                pending_angles.push_back(svd_pkg::ANGLE_W'($urandom_range(0, 359)));
        end
        angles_queued += count;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        mod_index       = svd_pkg::MODULATION_RESET;
        period          = svd_pkg::PERIOD_RESET;
        idle_pct        = IDLE_PCT;
        angles_queued   = 0;
        angles_sent     = 0;
        results_checked = 0;
        settings_used   = 1;
        mismatches      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (boundary_angles[i])
            pending_angles.push_back(boundary_angles[i]);
        angles_queued += 20;
        drain();

        set_drive(16'd0, 16'd65535);
        run_angles(40);
        set_drive(16'd65535, 16'd65535);
        run_angles(60);
        set_drive(16'd32768, 16'd0);
        run_angles(30);
        set_drive(16'd1, 16'd1);
        run_angles(30);

        // spare indexes must leave both registers alone
        write_reg(CFG_SPARE_FIRST, svd_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_LAST, svd_pkg::CFG_DATA_W'($urandom));
        run_angles(30);

        for (int k = 0; k < 5; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                set_drive(svd_pkg::CFG_DATA_W'($urandom), svd_pkg::CFG_DATA_W'($urandom));
            else
                set_drive(svd_pkg::CFG_DATA_W'($urandom_range(0, 32768)),
                          svd_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
            idle_pct = (k == 2) ? 0 : IDLE_PCT;
            run_angles((k == 2) ? 100 : 55);
        end
        idle_pct = IDLE_PCT;

        repeat (LATENCY * 4) @(posedge clk);
        $display("covered %0d angle transactions under %0d drive settings",
                 angles_sent, settings_used);
        $display("checked %0d duty results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_duties.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_duties.size());
        $display("status: fail");
        $finish;
    end

endmodule

[space_vector_duty_calculator_core.f]
hdl/svd_pkg.sv
hdl/svd_if.sv
hdl/svd_sector.sv
hdl/svd_coef.sv
hdl/svd_mult.sv
hdl/svd_sat.sv
hdl/space_vector_duty_calculator_core.sv
verif/testbench.sv
